// ===== hdl/prt_pkg.sv =====
// Package for the 3D point rotation unit: command and axis codes, trig formats,
// and the per-stage load struct shared by the pipeline modules.
// Depends on nothing.
package prt_pkg;

  // Operation selected by the cmd field of an item.
  typedef enum logic [1:0] {
    CMD_ROT_X   = 2'd0,
    CMD_ROT_Y   = 2'd1,
    CMD_ROT_Z   = 2'd2,
    CMD_ROT_YXZ = 2'd3
  } cmd_t;

  // Axis that one rotation stage turns about.
  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  // Sine and cosine are signed Q1.14.
  localparam int TRIG_BITS = 16;
  localparam int TRIG_FRAC = 14;

  typedef logic signed [TRIG_BITS-1:0] trig_t;

  // Load enables of a module that holds two register stages.
  typedef struct packed {
    logic load_a;
    logic load_b;
  } stage_en_t;

  // True when a rotation about the given axis is part of the command.
  function automatic logic axis_active(input axis_t axis, input cmd_t cmd);
    logic hit;
    hit = (cmd == CMD_ROT_YXZ);
    unique case (axis)
      AXIS_X: hit = hit || (cmd == CMD_ROT_X);
      AXIS_Y: hit = hit || (cmd == CMD_ROT_Y);
      AXIS_Z: hit = hit || (cmd == CMD_ROT_Z);
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ===== hdl/prt_sincos.sv =====
// Two-stage sine/cosine lookup: a quarter-wave ROM built at elaboration, then
// quadrant folding to signed Q1.14. Depends on prt_pkg.
module prt_sincos import prt_pkg::*; #(
  parameter int ANGLE_BITS = 12
) (
  input  logic                  clk,
  input  stage_en_t             load,
  input  logic [ANGLE_BITS-1:0] angle_in,
  output trig_t                 sin_out,
  output trig_t                 cos_out
);

  localparam int RW           = ANGLE_BITS - 2;
  localparam int QDEPTH       = 1 << RW;
  localparam int QW           = TRIG_FRAC + 1;
  localparam int TAYLOR_TERMS = 14;

  localparam logic [63:0] TWO_PI_Q60 = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] ONE_Q60    = 64'd1 << 60;

  localparam logic [63:0] SIN_DIV [TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
    64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812
  };
  localparam logic [63:0] COS_DIV [TAYLOR_TERMS] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
    64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756
  };

  typedef logic [2*QW-1:0] qtab_t [QDEPTH];

  // (a*b) >> 60 for unsigned Q60 values, built from 32-bit halves.
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah, al, bh, bl, mid;
    ah  = a >> 32;
    al  = a & 64'hFFFF_FFFF;
    bh  = b >> 32;
    bl  = b & 64'hFFFF_FFFF;
    mid = ah * bl + al * bh;
    return ((ah * bh) << 4) + (mid >> 28) + ((al * bl) >> 60);
  endfunction

  // Quarter-wave table, each entry {sin, cos} rounded to Q1.14. The angle of
  // entry k is k/2^ANGLE_BITS of a turn, evaluated by a Q60 Taylor series.
  function automatic qtab_t build_tab();
    qtab_t       tab;
    logic [63:0] r, hi, lo, theta, x2, ts, tc, sv, cv, sq, cq;
    for (int k = 0; k < QDEPTH; k++) begin
      r     = 64'(k);
      hi    = r * (TWO_PI_Q60 >> 32);
      lo    = r * (TWO_PI_Q60 & 64'hFFFF_FFFF);
      theta = (hi << (32 - ANGLE_BITS)) + (lo >> ANGLE_BITS);
      x2    = mul_q60(theta, theta);
      ts    = theta;
      tc    = ONE_Q60;
      sv    = theta;
      cv    = ONE_Q60;
      for (int n = 0; n < TAYLOR_TERMS; n++) begin
        ts = mul_q60(ts, x2) / SIN_DIV[n];
        tc = mul_q60(tc, x2) / COS_DIV[n];
        if ((n & 1) == 0) begin
          sv = sv - ts;
          cv = cv - tc;
        end else begin
          sv = sv + ts;
          cv = cv + tc;
        end
      end
      sq     = (sv + (64'd1 << 45)) >> 46;
      cq     = (cv + (64'd1 << 45)) >> 46;
      tab[k] = {sq[QW-1:0], cq[QW-1:0]};
    end
    return tab;
  endfunction

  localparam qtab_t TRIG_TAB = build_tab();

  logic [2*QW-1:0] tab_q;
  logic [1:0]      quad_q;
  trig_t           s_mag, c_mag, sin_next, cos_next;

  // Registered ROM read.
  always_ff @(posedge clk) begin
    if (load.load_a) begin
      tab_q  <= TRIG_TAB[angle_in[RW-1:0]];
      quad_q <= angle_in[ANGLE_BITS-1 -: 2];
    end
  end

  assign s_mag = trig_t'({1'b0, tab_q[2*QW-1:QW]});
  assign c_mag = trig_t'({1'b0, tab_q[QW-1:0]});

  // Fold the quarter-wave values into the quadrant given by the top angle bits.
  always_comb begin
    case (quad_q)
      2'd0: begin
        sin_next = s_mag;
        cos_next = c_mag;
      end
      2'd1: begin
        sin_next = c_mag;
        cos_next = -s_mag;
      end
      2'd2: begin
        sin_next = -s_mag;
        cos_next = -c_mag;
      end
      default: begin
        sin_next = -c_mag;
        cos_next = s_mag;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load.load_b) begin
      sin_out <= sin_next;
      cos_out <= cos_next;
    end
  end

endmodule

// ===== hdl/prt_rot_stage.sv =====
// One rotation about a fixed axis in two register stages: four products, then
// round, saturate and merge. Depends on prt_pkg.
module prt_rot_stage import prt_pkg::*; #(
  parameter int    COORD_BITS = 16,
  parameter axis_t AXIS       = AXIS_X
) (
  input  logic                         clk,
  input  logic                         rst,
  input  stage_en_t                    load,
  input  cmd_t                         cmd_in,
  input  logic signed [COORD_BITS-1:0] x_in,
  input  logic signed [COORD_BITS-1:0] y_in,
  input  logic signed [COORD_BITS-1:0] z_in,
  input  trig_t                        sin_in,
  input  trig_t                        cos_in,
  input  logic                         clip_in,
  output cmd_t                         cmd_out,
  output logic signed [COORD_BITS-1:0] x_out,
  output logic signed [COORD_BITS-1:0] y_out,
  output logic signed [COORD_BITS-1:0] z_out,
  output trig_t                        sin_out,
  output trig_t                        cos_out,
  output logic                         clip_out
);

  localparam int PW   = COORD_BITS + TRIG_BITS;
  localparam int SUMW = PW + 1;

  localparam logic signed [SUMW-1:0] RND    = SUMW'(1) << (TRIG_FRAC - 1);
  localparam logic signed [SUMW-1:0] SAT_HI = {{(SUMW-COORD_BITS+1){1'b0}},
                                               {(COORD_BITS-1){1'b1}}};
  localparam logic signed [SUMW-1:0] SAT_LO = {{(SUMW-COORD_BITS+1){1'b1}},
                                               {(COORD_BITS-1){1'b0}}};

  logic signed [COORD_BITS-1:0] a_in, b_in;

  // First stage registers.
  cmd_t                         cmd_a;
  logic signed [COORD_BITS-1:0] x_a, y_a, z_a;
  trig_t                        sin_a, cos_a;
  logic                         clip_a, en_a;
  logic signed [PW-1:0]         ac_q, bs_q, as_q, bc_q;

  // Second stage logic.
  logic signed [SUMW-1:0]       sum_a, sum_b, sh_a, sh_b;
  logic                         hi_a, lo_a, hi_b, lo_b;
  logic signed [COORD_BITS-1:0] new_a, new_b;
  logic signed [COORD_BITS-1:0] x_next, y_next, z_next;
  logic                         clip_next;

  // The rotated pair (a, b) follows a' = a*c - b*s, b' = a*s + b*c.
  always_comb begin
    unique case (AXIS)
      AXIS_X: begin
        a_in = y_in;
        b_in = z_in;
      end
      AXIS_Y: begin
        a_in = z_in;
        b_in = x_in;
      end
      default: begin
        a_in = x_in;
        b_in = y_in;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load.load_a) begin
      cmd_a  <= cmd_in;
      x_a    <= x_in;
      y_a    <= y_in;
      z_a    <= z_in;
      sin_a  <= sin_in;
      cos_a  <= cos_in;
      clip_a <= clip_in;
      en_a   <= axis_active(AXIS, cmd_in);
      ac_q   <= PW'(a_in) * PW'(cos_in);
      bs_q   <= PW'(b_in) * PW'(sin_in);
      as_q   <= PW'(a_in) * PW'(sin_in);
      bc_q   <= PW'(b_in) * PW'(cos_in);
    end
  end

  // Round to nearest by adding half an LSB and shifting with floor, then clamp.
  always_comb begin
    sum_a = SUMW'(ac_q) - SUMW'(bs_q) + RND;
    sum_b = SUMW'(as_q) + SUMW'(bc_q) + RND;
    sh_a  = sum_a >>> TRIG_FRAC;
    sh_b  = sum_b >>> TRIG_FRAC;
    hi_a  = sh_a > SAT_HI;
    lo_a  = sh_a < SAT_LO;
    hi_b  = sh_b > SAT_HI;
    lo_b  = sh_b < SAT_LO;
    new_a = hi_a ? SAT_HI[COORD_BITS-1:0] : (lo_a ? SAT_LO[COORD_BITS-1:0] : sh_a[COORD_BITS-1:0]);
    new_b = hi_b ? SAT_HI[COORD_BITS-1:0] : (lo_b ? SAT_LO[COORD_BITS-1:0] : sh_b[COORD_BITS-1:0]);
  end

  always_comb begin
    x_next    = x_a;
    y_next    = y_a;
    z_next    = z_a;
    clip_next = clip_a;
    if (en_a) begin
      clip_next = clip_a | hi_a | lo_a | hi_b | lo_b;
      unique case (AXIS)
        AXIS_X: begin
          y_next = new_a;
          z_next = new_b;
        end
        AXIS_Y: begin
          z_next = new_a;
          x_next = new_b;
        end
        default: begin
          x_next = new_a;
          y_next = new_b;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load.load_b) begin
      cmd_out  <= cmd_a;
      x_out    <= x_next;
      y_out    <= y_next;
      z_out    <= z_next;
      sin_out  <= sin_a;
      cos_out  <= cos_a;
      clip_out <= clip_next;
    end
  end

  // A stage that the command does not select leaves the point untouched.
  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    (load.load_b && !en_a) |=>
      (x_out == $past(x_a)) && (y_out == $past(y_a)) && (z_out == $past(z_a)) &&
      (clip_out == $past(clip_a)))
    else $error("unselected rotation stage changed the point");

  // The clip flag of an item is never dropped by a later stage.
  a_clip_sticky: assert property (@(posedge clk) disable iff (rst)
    (load.load_b && clip_a) |=> clip_out)
    else $error("clip flag lost in rotation stage");

endmodule

// ===== hdl/point_rotation_3d_unit.sv =====
// Throughput one item per cycle while out_stall is low; a stalled output holds the items in
// their stages. Stages: sin/cos ROM read, quadrant fold, then Y, X and Z rotations
// of two stages each (products, then round and saturate). Reset (rst, synchronous)
// clears only the stage valid bits; payload registers are not reset.
module point_rotation_3d_unit import prt_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int ANGLE_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   cmd,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  input  logic [ANGLE_BITS-1:0]        turn_angle,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] rot_x,
  output logic signed [COORD_BITS-1:0] rot_y,
  output logic signed [COORD_BITS-1:0] rot_z,
  output logic                         clipped
);

  // Stage numbering: 0-1 angle lookup, 2-3 about Y, 4-5 about X, 6-7 about Z.
  localparam int NST = 8;

  // One valid bit per register stage. A stage may load when it is empty or
  // when the stage after it is loading; this fills bubbles, so a stalled
  // output does not stop items from moving up behind it.
  logic [NST-1:0] stage_valid;
  logic [NST-1:0] up_valid;
  logic [NST:0]   ready;
  logic [NST-1:0] load;

  assign up_valid = {stage_valid[NST-2:0], in_valid};

  always_comb begin
    ready[NST] = !out_stall;
    for (int i = NST - 1; i >= 0; i--) begin
      ready[i] = !stage_valid[i] || ready[i+1];
    end
  end

  assign load = ready[NST-1:0] & up_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (ready[i]) begin
          stage_valid[i] <= up_valid[i];
        end
      end
    end
  end

  assign in_stall  = !ready[0];
  assign out_valid = stage_valid[NST-1];

  // The point and command wait in these registers while the angle lookup runs.
  cmd_t                         cmd_s0, cmd_s1;
  logic signed [COORD_BITS-1:0] x_s0, y_s0, z_s0, x_s1, y_s1, z_s1;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      cmd_s0 <= cmd_t'(cmd);
      x_s0   <= point_x;
      y_s0   <= point_y;
      z_s0   <= point_z;
    end
    if (load[1]) begin
      cmd_s1 <= cmd_s0;
      x_s1   <= x_s0;
      y_s1   <= y_s0;
      z_s1   <= z_s0;
    end
  end

  trig_t sin_s1, cos_s1;

  prt_sincos #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_sincos (
    .clk      (clk),
    .load     ('{load_a: load[0], load_b: load[1]}),
    .angle_in (turn_angle),
    .sin_out  (sin_s1),
    .cos_out  (cos_s1)
  );

  // Three rotation stages in the order the chained command needs: Y, X, Z.
  // A stage the command does not select passes the point through, so every
  // command sees the same latency and items never reorder.
  cmd_t                         cmd_y, cmd_x, cmd_z;
  logic signed [COORD_BITS-1:0] x_y, y_y, z_y, x_x, y_x, z_x;
  trig_t                        sin_y, cos_y, sin_x, cos_x, sin_z, cos_z;
  logic                         clip_y, clip_x;

  prt_rot_stage #(
    .COORD_BITS(COORD_BITS),
    .AXIS      (AXIS_Y)
  ) u_rot_y (
    .clk      (clk),
    .rst      (rst),
    .load     ('{load_a: load[2], load_b: load[3]}),
    .cmd_in   (cmd_s1),
    .x_in     (x_s1),
    .y_in     (y_s1),
    .z_in     (z_s1),
    .sin_in   (sin_s1),
    .cos_in   (cos_s1),
    .clip_in  (1'b0),
    .cmd_out  (cmd_y),
    .x_out    (x_y),
    .y_out    (y_y),
    .z_out    (z_y),
    .sin_out  (sin_y),
    .cos_out  (cos_y),
    .clip_out (clip_y)
  );

  prt_rot_stage #(
    .COORD_BITS(COORD_BITS),
    .AXIS      (AXIS_X)
  ) u_rot_x (
    .clk      (clk),
    .rst      (rst),
    .load     ('{load_a: load[4], load_b: load[5]}),
    .cmd_in   (cmd_y),
    .x_in     (x_y),
    .y_in     (y_y),
    .z_in     (z_y),
    .sin_in   (sin_y),
    .cos_in   (cos_y),
    .clip_in  (clip_y),
    .cmd_out  (cmd_x),
    .x_out    (x_x),
    .y_out    (y_x),
    .z_out    (z_x),
    .sin_out  (sin_x),
    .cos_out  (cos_x),
    .clip_out (clip_x)
  );

  // The last stage's output registers are the block's output registers.
  prt_rot_stage #(
    .COORD_BITS(COORD_BITS),
    .AXIS      (AXIS_Z)
  ) u_rot_z (
    .clk      (clk),
    .rst      (rst),
    .load     ('{load_a: load[6], load_b: load[7]}),
    .cmd_in   (cmd_x),
    .x_in     (x_x),
    .y_in     (y_x),
    .z_in     (z_x),
    .sin_in   (sin_x),
    .cos_in   (cos_x),
    .clip_in  (clip_x),
    .cmd_out  (cmd_z),
    .x_out    (rot_x),
    .y_out    (rot_y),
    .z_out    (rot_z),
    .sin_out  (sin_z),
    .cos_out  (cos_z),
    .clip_out (clipped)
  );

  // The input is held off only when every stage is full and the output stalls.
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ((&stage_valid) && out_stall))
    else $error("input stalled while the pipeline has room");

  // After reset the pipeline holds no item.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (stage_valid == '0))
    else $error("stage valid bits survive reset");

  // An item blocked by the stage after it stays where it is.
  for (genvar g = 0; g < NST; g++) begin : g_hold
    a_stage_hold: assert property (@(posedge clk) disable iff (rst)
      (stage_valid[g] && !ready[g+1]) |=> stage_valid[g])
      else $error("item dropped from a blocked stage");
  end

  // Command and trig values leave the last stage unused.
  logic unused_tail;
  assign unused_tail = ^{cmd_z, sin_z, cos_z};

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for point_rotation_3d_unit: random and directed points, all commands.
// A scoreboard class predicts each rotated point bit for bit from its own sine/cosine table.
// Depends on prt_pkg and the point_rotation_3d_unit RTL.
module testbench;
  import prt_pkg::*;

  localparam int COORD_W = 16;
  localparam int ANGLE_W = 12;
  localparam int FOLD_STEPS = 2 ** (ANGLE_W - 2);
  localparam int LATENCY = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
  localparam logic [63:0] ONE_Q60 = 64'd1 << 60;

  typedef logic signed [COORD_W-1:0] coord_t;

  // One rotated point as the block should present it.
  typedef struct {
    coord_t rx;
    coord_t ry;
    coord_t rz;
    logic   clip;
  } rotated_point_t;

  // Predicts every accepted point and holds the expectations in arrival order.
  class rotation_scoreboard;
    longint sin_fold[FOLD_STEPS];
    longint cos_fold[FOLD_STEPS];
    rotated_point_t expected_points[$];
    int mismatches;

    function new();
      mismatches = 0;
      build_trig();
    endfunction

    // (a*b) >> 60 on unsigned Q60 values, split into 32-bit halves.
    function logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
      logic [63:0] ah, al, bh, bl, mid;
      ah = a >> 32;
      al = a & 64'hFFFF_FFFF;
      bh = b >> 32;
      bl = b & 64'hFFFF_FFFF;
      mid = ah * bl + al * bh;
      return ((ah * bh) << 4) + (mid >> 28) + ((al * bl) >> 60);
    endfunction

    // First-quadrant sine and cosine in Q1.14 from a Taylor series in Q60.
    function void build_trig();
      logic [63:0] r, hi, lo, theta, x2, ts, tc, sv, cv, n;
      for (int k = 0; k < FOLD_STEPS; k++) begin
        r = 64'(k);
        hi = r * (TWO_PI_Q60 >> 32);
        lo = r * (TWO_PI_Q60 & 64'hFFFF_FFFF);
        theta = (hi << (32 - ANGLE_W)) + (lo >> ANGLE_W);
        x2 = mul_q60(theta, theta);
        ts = theta;
        tc = ONE_Q60;
        sv = theta;
        cv = ONE_Q60;
        for (n = 1; n <= 14; n++) begin
          ts = mul_q60(ts, x2) / ((2 * n) * (2 * n + 1));
          tc = mul_q60(tc, x2) / ((2 * n - 1) * (2 * n));
          if (n[0]) begin
            sv = sv - ts;
            cv = cv - tc;
          end else begin
            sv = sv + ts;
            cv = cv + tc;
          end
        end
        sin_fold[k] = longint'((sv + (64'd1 << 45)) >> 46);
        cos_fold[k] = longint'((cv + (64'd1 << 45)) >> 46);
      end
    endfunction

    // Round a Q14 product sum back to coordinate units and clamp it.
    function longint round_clamp(input longint sum, inout bit clip);
      longint v, hi_lim, lo_lim;
      hi_lim = (longint'(1) <<< (COORD_W - 1)) - 1;
      lo_lim = -hi_lim - 1;
      v = (sum + 8192) >>> 14;
      if (v > hi_lim) begin
        clip = 1'b1;
        return hi_lim;
      end
      if (v < lo_lim) begin
        clip = 1'b1;
        return lo_lim;
      end
      return v;
    endfunction

    // a' = a*c - b*s, b' = a*s + b*c
    function void turn_pair(inout longint a, inout longint b, input longint s,
                            input longint c, inout bit clip);
      longint na, nb;
      na = round_clamp(a * c - b * s, clip);
      nb = round_clamp(a * s + b * c, clip);
      a = na;
      b = nb;
    endfunction

    function rotated_point_t rotate_point(cmd_t op, coord_t px, coord_t py, coord_t pz,
                                          logic [ANGLE_W-1:0] ang);
      longint x, y, z, s, c, s0, c0;
      bit clip;
      rotated_point_t res;
      x = longint'(px);
      y = longint'(py);
      z = longint'(pz);
      clip = 1'b0;
      s0 = sin_fold[ang[ANGLE_W-3:0]];
      c0 = cos_fold[ang[ANGLE_W-3:0]];
      // Fold the quarter-turn table out to the full circle.
      case (ang[ANGLE_W-1:ANGLE_W-2])
        2'd0: begin s = s0;  c = c0;  end
        2'd1: begin s = c0;  c = -s0; end
        2'd2: begin s = -s0; c = -c0; end
        default: begin s = -c0; c = s0; end
      endcase
      case (op)
        CMD_ROT_X: turn_pair(y, z, s, c, clip);
        CMD_ROT_Y: turn_pair(z, x, s, c, clip);
        CMD_ROT_Z: turn_pair(x, y, s, c, clip);
        default: begin
          turn_pair(z, x, s, c, clip);
          turn_pair(y, z, s, c, clip);
          turn_pair(x, y, s, c, clip);
        end
      endcase
      res.rx = x[COORD_W-1:0];
      res.ry = y[COORD_W-1:0];
      res.rz = z[COORD_W-1:0];
      res.clip = clip;
      return res;
    endfunction

    function void note_point(cmd_t op, coord_t px, coord_t py, coord_t pz,
                             logic [ANGLE_W-1:0] ang);
      expected_points.push_back(rotate_point(op, px, py, pz, ang));
    endfunction

    function void check_rotated(coord_t ax, coord_t ay, coord_t az, logic aclip);
      rotated_point_t exp_pt;
      if (expected_points.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result x=%0d y=%0d z=%0d clipped=%b",
                 $time, ax, ay, az, aclip);
        return;
      end
      exp_pt = expected_points.pop_front();
      if (ax !== exp_pt.rx) begin
        mismatches++;
        $display("%0t: rot_x expected %0d actual %0d", $time, exp_pt.rx, ax);
      end
      if (ay !== exp_pt.ry) begin
        mismatches++;
        $display("%0t: rot_y expected %0d actual %0d", $time, exp_pt.ry, ay);
      end
      if (az !== exp_pt.rz) begin
        mismatches++;
        $display("%0t: rot_z expected %0d actual %0d", $time, exp_pt.rz, az);
      end
      if (aclip !== exp_pt.clip) begin
        mismatches++;
        $display("%0t: clipped expected %b actual %b", $time, exp_pt.clip, aclip);
      end
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  cmd_t cmd = CMD_ROT_X;
  coord_t point_x = '0;
  coord_t point_y = '0;
  coord_t point_z = '0;
  logic [ANGLE_W-1:0] turn_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  coord_t rot_x;
  coord_t rot_y;
  coord_t rot_z;
  logic clipped;

  rotation_scoreboard sb = new();

  // Random idling on both sides is on until the closing stretch of the run.
  bit idle_on = 1'b1;
  // Each increment asks the receiver for one long hold-off.
  int hold_req = 0;
  int cycle_count = 0;

  point_rotation_3d_unit #(
    .COORD_BITS(COORD_W),
    .ANGLE_BITS(ANGLE_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .point_x(point_x),
    .point_y(point_y),
    .point_z(point_z),
    .turn_angle(turn_angle),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .rot_x(rot_x),
    .rot_y(rot_y),
    .rot_z(rot_z),
    .clipped(clipped)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a stuck handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL point_rotation_3d_unit");
      $finish;
    end
  end

  // Both channels are sampled at the rising edge, before the block's registers move.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      sb.note_point(cmd, point_x, point_y, point_z, turn_angle);
    end
    if (!rst && out_valid && !out_stall) begin
      sb.check_rotated(rot_x, rot_y, rot_z, clipped);
    end
  end

  // Receiver: random stall bursts, plus a long hold-off whenever one is requested.
  // The hold-off is counted here so the sender keeps offering items meanwhile.
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Offer one item at the falling edge and return at the rising edge that accepts it.
  // The item stays on the bus until the next call or until the sender drops valid.
  task automatic send_point(input cmd_t op, input coord_t px, input coord_t py,
                            input coord_t pz, input logic [ANGLE_W-1:0] ang);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    cmd = op;
    point_x = px;
    point_y = py;
    point_z = pz;
    turn_angle = ang;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait until every predicted point has come out.
  task automatic drain_points();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Mix of full-range, small, and near-limit coordinates so that both the
  // plain path and the saturating path see plenty of traffic.
  function automatic coord_t pick_coord();
    case ($urandom_range(0, 3))
      0: return coord_t'(int'($urandom_range(0, 1023)) - 512);
      1: return $urandom_range(0, 1) ? coord_t'(32767 - $urandom_range(0, 255))
                                     : coord_t'(-32768 + $urandom_range(0, 255));
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Angles favor the quadrant seams, where sine or cosine is exactly one.
  function automatic logic [ANGLE_W-1:0] pick_angle();
    logic [ANGLE_W-1:0] seam;
    if ($urandom_range(0, 4) == 0) begin
      seam = '0;
      seam[ANGLE_W-1:ANGLE_W-2] = 2'($urandom_range(0, 3));
      return seam + ANGLE_W'($urandom_range(0, 2)) - ANGLE_W'(1);
    end
    return ANGLE_W'($urandom);
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_point(cmd_t'($urandom_range(0, 3)), pick_coord(), pick_coord(), pick_coord(),
                 pick_angle());
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed points: zero and quarter turns, coordinate extremes, every command,
    // sine or cosine of exactly one, and sums that must clamp.
    send_point(CMD_ROT_X, 16'sd100, 16'sd200, 16'sd300, 12'd0);
    send_point(CMD_ROT_Y, 16'sd100, 16'sd200, 16'sd300, 12'd1024);
    send_point(CMD_ROT_Z, 16'sd100, 16'sd200, 16'sd300, 12'd2048);
    send_point(CMD_ROT_YXZ, 16'sd100, 16'sd200, 16'sd300, 12'd3072);
    send_point(CMD_ROT_X, 16'sd32767, 16'sd32767, 16'sd32767, 12'd4095);
    send_point(CMD_ROT_Y, -16'sd32768, -16'sd32768, -16'sd32768, 12'd1);
    send_point(CMD_ROT_Z, 16'sd32767, -16'sd32768, 16'sd0, 12'd1024);
    send_point(CMD_ROT_Z, -16'sd32768, 16'sd0, 16'sd0, 12'd2048);
    send_point(CMD_ROT_X, 16'sd0, -16'sd32768, 16'sd32767, 12'd3072);
    // Forty-five degrees: one output sums to about 1.41 times full scale.
    send_point(CMD_ROT_Z, 16'sd32767, 16'sd32767, 16'sd0, 12'd512);
    send_point(CMD_ROT_X, 16'sd0, 16'sd32767, 16'sd32767, 12'd3584);
    send_point(CMD_ROT_Y, -16'sd32768, 16'sd0, 16'sd32767, 12'd1536);
    // Chained command with clipping in early and late stages.
    send_point(CMD_ROT_YXZ, 16'sd32767, 16'sd32767, 16'sd32767, 12'd512);
    send_point(CMD_ROT_YXZ, -16'sd32768, 16'sd32767, -16'sd32768, 12'd2560);
    send_point(CMD_ROT_YXZ, 16'sd32767, 16'sd0, 16'sd0, 12'd1024);
    send_point(CMD_ROT_YXZ, 16'sd0, 16'sd0, 16'sd0, 12'd4095);
    send_point(CMD_ROT_YXZ, -16'sd1, 16'sd1, -16'sd1, 12'd2047);
    send_point(CMD_ROT_X, 16'sd1, -16'sd1, 16'sd1, 12'd1023);
    send_point(CMD_ROT_Y, 16'sd20000, 16'sd5, 16'sd20000, 12'd341);
    send_point(CMD_ROT_Z, -16'sd25000, 16'sd25000, 16'sd7, 12'd3413);

    send_random(220);

    // Long receiver hold-off while the sender keeps offering items, so that the
    // pipeline fills and its input stall rises.
    hold_req++;
    send_random(40);
    // Sender pause: nothing more until every predicted point is out.
    drain_points();

    send_random(220);

    // Closing stretch with no idling on either side.
    idle_on = 1'b0;
    send_random(120);
    drain_points();
    repeat (LATENCY * 2) @(negedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS point_rotation_3d_unit");
    end else begin
      $display("FAIL point_rotation_3d_unit");
    end
    $finish;
  end
endmodule
